@@ rtl/pressure_temp_compensation_unit_defines.svh @@
// Assertion macros shared by the compensation unit RTL.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef PRESSURE_TEMP_COMPENSATION_UNIT_DEFINES_SVH
`define PRESSURE_TEMP_COMPENSATION_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define PTC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ptc assertion failed");

// Next-cycle implication, checked outside reset
`define PTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ptc assertion failed");

`endif

@@ rtl/ptc_pkg.sv @@
// Package for the pressure/temperature compensation unit: sequencer states,
// register indexes, constants and fixed-point helper functions. No dependencies.
package ptc_pkg;

    typedef enum logic [4:0] {
        S_IDLE,
        S_T1, S_T2, S_T3,
        S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
        S_P10, S_P11, S_P12, S_P13, S_P14,
        S_DIV,
        S_OUT
    } ptc_state_t;

    typedef enum logic [2:0] {
        REG_AC123   = 3'd0,
        REG_AC456   = 3'd1,
        REG_B12     = 3'd2,
        REG_MCMD    = 3'd3,
        REG_OSS     = 3'd4,
        REG_LIM_LO  = 3'd5,
        REG_LIM_HI  = 3'd6
    } ptc_reg_idx_t;

    localparam logic signed [31:0] B6_OFFSET   = 32'sd4000;
    localparam logic [31:0]        X3_OFFSET   = 32'd32768;
    localparam logic [31:0]        B7_SCALE    = 32'd50000;
    localparam logic signed [31:0] K_SQ        = 32'sd3038;
    localparam logic signed [31:0] K_LIN       = -32'sd7357;
    localparam logic signed [31:0] K_OFS       = 32'sd3791;
    localparam logic [1:0]         OSS_RESET   = 2'd2;
    localparam logic signed [15:0] LIM_LO_RST  = -16'sd400;
    localparam logic signed [15:0] LIM_HI_RST  = 16'sd850;

    // Signed divide by 2^n, truncating toward zero
    function automatic logic signed [31:0] div_p2(input logic signed [31:0] x, input int n);
        logic [31:0] bias;
        bias = x[31] ? ((32'd1 << n) - 32'd1) : 32'd0;
        return $signed(x + bias) >>> n;
    endfunction

    // Sign-extend a 16-bit coefficient
    function automatic logic signed [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

@@ rtl/pressure_temp_compensation_unit.sv @@
// Compensation unit: one item in flight at a time. The steps run on the shared 32-bit
// restoring divider (one quotient bit per cycle) and on the shared 32x32 multiplier,
// with one sequencer state per arithmetic step: 2 states before and 1 after the
// divide for temperature, 9 before and 5 after for pressure, then one state to load
// the output register before the sequencer returns to idle. A zero divisor skips the
// divide and the steps after it. s_ready is high only while the sequencer is idle; a
// result sits in the output register until its transfer completes, and a stalled
// output holds the sequencer in its load state. A temperature item with a nonzero
// divisor also updates the kept B5 term that later pressure items use.
`include "pressure_temp_compensation_unit_defines.svh"
module pressure_temp_compensation_unit
    import ptc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [47:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic [18:0]        s_raw_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_result_value,
    output logic               m_is_pressure,
    output logic               m_temp_out_of_range,
    output logic               m_divide_fault
);

    // Configuration registers
    logic [47:0]        ac123_reg, ac456_reg;
    logic [31:0]        b12_reg, mcmd_reg;
    logic [1:0]         oss_reg;
    logic signed [15:0] lim_lo_reg, lim_hi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ac123_reg  <= '0;
            ac456_reg  <= '0;
            b12_reg    <= '0;
            mcmd_reg   <= '0;
            oss_reg    <= OSS_RESET;
            lim_lo_reg <= LIM_LO_RST;
            lim_hi_reg <= LIM_HI_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_AC123:  ac123_reg  <= cfg_wdata;
                REG_AC456:  ac456_reg  <= cfg_wdata;
                REG_B12:    b12_reg    <= cfg_wdata[31:0];
                REG_MCMD:   mcmd_reg   <= cfg_wdata[31:0];
                REG_OSS:    oss_reg    <= cfg_wdata[1:0];
                REG_LIM_LO: lim_lo_reg <= cfg_wdata[15:0];
                REG_LIM_HI: lim_hi_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [31:0]        ac4, ac5, ac6;
    assign ac1 = sx16(ac123_reg[47:32]);
    assign ac2 = sx16(ac123_reg[31:16]);
    assign ac3 = sx16(ac123_reg[15:0]);
    assign ac4 = {16'd0, ac456_reg[47:32]};
    assign ac5 = {16'd0, ac456_reg[31:16]};
    assign ac6 = {16'd0, ac456_reg[15:0]};
    assign b1  = sx16(b12_reg[31:16]);
    assign b2  = sx16(b12_reg[15:0]);
    assign mc  = sx16(mcmd_reg[31:16]);
    assign md  = sx16(mcmd_reg[15:0]);

    // Sequencer and datapath registers
    ptc_state_t         state_reg, state_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               prs_reg, prs_next;
    logic [18:0]        raw_reg, raw_next;
    logic [31:0]        prod_reg, prod_next;
    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] sq_reg, sq_next;
    logic signed [31:0] b6_reg, b6_next;
    logic signed [31:0] b3_reg, b3_next;
    logic [31:0]        b4_reg, b4_next;
    logic signed [31:0] p_reg, p_next;
    logic signed [31:0] b5_reg, b5_next;
    logic [31:0]        dvd_reg, dvd_next;
    logic [32:0]        rem_reg, rem_next;
    logic [31:0]        dvs_reg, dvs_next;
    logic               neg_reg, neg_next;
    logic               dbl_reg, dbl_next;
    logic signed [31:0] res_reg, res_next;
    logic               oor_reg, oor_next;
    logic               flt_reg, flt_next;
    logic               m_valid_reg, m_valid_next;
    logic signed [31:0] m_res_reg, m_res_next;
    logic               m_prs_reg, m_prs_next, m_oor_reg, m_oor_next, m_flt_reg, m_flt_next;

    logic               s_xfer, out_free;
    logic [31:0]        mul_a, mul_b;
    logic signed [31:0] den, x1t, b5t, tval, pval, q_s;
    logic [32:0]        rem_sh, rem_sub;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_xfer   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_xfer) state_next = s_cmd ? S_P1 : S_T1;
            S_T1:   state_next = S_T2;
            S_T2:   state_next = (den == 32'sd0) ? S_OUT : S_DIV;
            S_T3:   state_next = S_OUT;
            S_P1:   state_next = S_P2;
            S_P2:   state_next = S_P3;
            S_P3:   state_next = S_P4;
            S_P4:   state_next = S_P5;
            S_P5:   state_next = S_P6;
            S_P6:   state_next = S_P7;
            S_P7:   state_next = S_P8;
            S_P8:   state_next = S_P9;
            S_P9:   state_next = (b4_reg == 32'd0) ? S_OUT : S_DIV;
            S_P10:  state_next = S_P11;
            S_P11:  state_next = S_P12;
            S_P12:  state_next = S_P13;
            S_P13:  state_next = S_P14;
            S_P14:  state_next = S_OUT;
            S_DIV:  if (cnt_reg == 5'd0) state_next = prs_reg ? S_P10 : S_T3;
            S_OUT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath: operand select for the shared multiplier and register updates
    always_comb begin
        cnt_next     = cnt_reg;
        prs_next     = prs_reg;
        raw_next     = raw_reg;
        x_next       = x_reg;
        sq_next      = sq_reg;
        b6_next      = b6_reg;
        b3_next      = b3_reg;
        b4_next      = b4_reg;
        p_next       = p_reg;
        b5_next      = b5_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        dvs_next     = dvs_reg;
        neg_next     = neg_reg;
        dbl_next     = dbl_reg;
        res_next     = res_reg;
        oor_next     = oor_reg;
        flt_next     = flt_reg;
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        m_prs_next   = m_prs_reg;
        m_oor_next   = m_oor_reg;
        m_flt_next   = m_flt_reg;
        mul_a        = '0;
        mul_b        = '0;

        x1t     = $signed(prod_reg) >>> 15;
        den     = x1t + md;
        q_s     = neg_reg ? -$signed(dvd_reg) : $signed(dvd_reg);
        b5t     = x_reg + q_s;
        tval    = (b5t + 32'sd8) >>> 4;
        pval    = p_reg + div_p2(x_reg + div_p2($signed(prod_reg), 16) + K_OFS, 4);
        rem_sh  = {rem_reg[31:0], dvd_reg[31]};
        rem_sub = rem_sh - {1'b0, dvs_reg};

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    prs_next = s_cmd;
                    raw_next = s_raw_value;
                    b6_next  = b5_reg - B6_OFFSET;
                end
            end
            // temperature: X1 = ((UT - AC6) * AC5) >> 15, then MC*2048 / (X1 + MD)
            S_T1: begin
                mul_a = {13'd0, raw_reg} - ac6;
                mul_b = ac5;
            end
            S_T2: begin
                x_next   = x1t;
                res_next = '0;
                oor_next = 1'b0;
                flt_next = (den == 32'sd0);
                dvd_next = mc[31] ? -(mc <<< 11) : (mc <<< 11);
                dvs_next = den[31] ? -den : den;
                neg_next = mc[31] ^ den[31];
                rem_next = '0;
                cnt_next = 5'd31;
            end
            S_T3: begin
                b5_next  = b5t;
                res_next = tval;
                oor_next = (tval <= 32'(lim_lo_reg)) || (tval >= 32'(lim_hi_reg));
            end
            // pressure: at most one product per state, consumed the state after
            S_P1: begin
                mul_a = b6_reg;
                mul_b = b6_reg;
            end
            S_P2: begin
                sq_next = div_p2($signed(prod_reg), 12);
                mul_a   = ac2;
                mul_b   = b6_reg;
            end
            S_P3: begin
                x_next = div_p2($signed(prod_reg), 11);
                mul_a  = b2;
                mul_b  = sq_reg;
            end
            S_P4: begin
                x_next = x_reg + div_p2($signed(prod_reg), 11);
                mul_a  = ac3;
                mul_b  = b6_reg;
            end
            S_P5: begin
                b3_next = div_p2((((ac1 <<< 2) + x_reg) <<< oss_reg) + 32'sd2, 2);
                x_next  = div_p2($signed(prod_reg), 13);
                mul_a   = b1;
                mul_b   = sq_reg;
            end
            S_P6: begin
                x_next = div_p2(x_reg + div_p2($signed(prod_reg), 16) + 32'sd2, 2);
            end
            S_P7: begin
                mul_a = ac4;
                mul_b = x_reg + X3_OFFSET;
            end
            S_P8: begin
                b4_next = prod_reg >> 15;
                mul_a   = {13'd0, raw_reg} - b3_reg;
                mul_b   = B7_SCALE >> oss_reg;
            end
            S_P9: begin
                res_next = '0;
                oor_next = 1'b0;
                flt_next = (b4_reg == 32'd0);
                dbl_next = prod_reg[31];
                dvd_next = prod_reg[31] ? prod_reg : (prod_reg << 1);
                dvs_next = b4_reg;
                neg_next = 1'b0;
                rem_next = '0;
                cnt_next = 5'd31;
            end
            S_P10: begin
                p_next = dbl_reg ? $signed(dvd_reg << 1) : $signed(dvd_reg);
            end
            S_P11: begin
                mul_a = div_p2(p_reg, 8);
                mul_b = div_p2(p_reg, 8);
            end
            S_P12: begin
                mul_a = prod_reg;
                mul_b = K_SQ;
            end
            S_P13: begin
                x_next = div_p2($signed(prod_reg), 16);
                mul_a  = K_LIN;
                mul_b  = p_reg;
            end
            S_P14: begin
                res_next = pval;
            end
            // restoring divide, one quotient bit per cycle
            S_DIV: begin
                if (!rem_sub[32]) begin
                    rem_next = rem_sub;
                    dvd_next = {dvd_reg[30:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    dvd_next = {dvd_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg - 5'd1;
            end
            // load the output register once the previous transfer is done
            S_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_res_next   = res_reg;
                    m_prs_next   = prs_reg;
                    m_oor_next   = oor_reg;
                    m_flt_next   = flt_reg;
                end
            end
            default: ;
        endcase

        prod_next = mul_a * mul_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            b5_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            b5_reg      <= b5_next;
        end
        cnt_reg   <= cnt_next;
        prs_reg   <= prs_next;
        raw_reg   <= raw_next;
        prod_reg  <= prod_next;
        x_reg     <= x_next;
        sq_reg    <= sq_next;
        b6_reg    <= b6_next;
        b3_reg    <= b3_next;
        b4_reg    <= b4_next;
        p_reg     <= p_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        neg_reg   <= neg_next;
        dbl_reg   <= dbl_next;
        res_reg   <= res_next;
        oor_reg   <= oor_next;
        flt_reg   <= flt_next;
        m_res_reg <= m_res_next;
        m_prs_reg <= m_prs_next;
        m_oor_reg <= m_oor_next;
        m_flt_reg <= m_flt_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_result_value      = m_res_reg;
    assign m_is_pressure       = m_prs_reg;
    assign m_temp_out_of_range = m_oor_reg;
    assign m_divide_fault      = m_flt_reg;

    `PTC_ASSERT_NEXT(a_accept_leaves_idle, s_xfer, state_reg != S_IDLE)
    `PTC_ASSERT_NOW(a_load_from_out, $rose(m_valid_reg), $past(state_reg) == S_OUT)
    `PTC_ASSERT_NOW(a_fault_zero, m_valid_reg && m_flt_reg, m_res_reg == 32'sd0)
    `PTC_ASSERT_NOW(a_press_no_oor, m_valid_reg && m_prs_reg, !m_oor_reg)

endmodule
